@@ rtl/mcerl_pkg.sv @@
package mcerl_pkg;

    localparam int RANGE_DEPTH = 16;
    localparam int ADDR_WIDTH  = 32;
    localparam int CNT_W       = $clog2(RANGE_DEPTH + 1);
    localparam int IDX_W       = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
    localparam int Q_DEPTH     = 2;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    // command codes of a request
    typedef enum logic [1:0] {
        CMD_CHECK = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SCAN  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic CFG_PATTERN     = 1'b0;
    localparam logic CFG_RANGE_LIMIT = 1'b1;

    // classified request, front to back
    typedef struct packed {
        t_cmd                  cmd;
        logic                  bad;
        logic [ADDR_WIDTH-1:0] addr;
        logic [ADDR_WIDTH:0]   end_addr;
        logic [3:0]            idx;
    } t_work;

    // one result
    typedef struct packed {
        logic        word_bad;
        logic [31:0] total_runs;
        logic [4:0]  stored_runs;
        logic        entry_valid;
        logic [31:0] entry_first;
        logic [32:0] entry_end;
    } t_result;

endpackage

@@ rtl/mcerl_front.sv @@
module mcerl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_command,
    input  logic [31:0]         i_word_address,
    input  logic [63:0]         i_word_data,
    input  logic [3:0]          i_entry_index,
    input  logic [63:0]         i_pattern,
    output logic                o_work_valid,
    output mcerl_pkg::t_work    o_work,
    input  logic                i_work_pop
);

    mcerl_pkg::t_work                     r_q [mcerl_pkg::Q_DEPTH];
    logic [mcerl_pkg::Q_PTR_W-1:0]        r_wptr;
    logic [mcerl_pkg::Q_PTR_W-1:0]        r_rptr;
    logic [mcerl_pkg::Q_CNT_W-1:0]        r_count;
    mcerl_pkg::t_work                     w_in;
    logic                                 w_push;
    logic                                 w_pop;

    // classify: mask test and end address
    always_comb begin
        w_in.cmd      = mcerl_pkg::t_cmd'(i_command);
        w_in.addr     = mcerl_pkg::ADDR_WIDTH'(i_word_address);
        w_in.end_addr = {1'b0, w_in.addr} + (mcerl_pkg::ADDR_WIDTH + 1)'(1);
        w_in.idx      = i_entry_index;
        w_in.bad      = (w_in.cmd == mcerl_pkg::CMD_CHECK) && ((i_word_data & ~i_pattern) != '0);
    end

    assign full         = (r_count == mcerl_pkg::Q_CNT_W'(mcerl_pkg::Q_DEPTH));
    assign w_push       = push && !full;
    assign o_work_valid = (r_count != '0);
    assign w_pop        = i_work_pop && o_work_valid;
    assign o_work       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_in;
        end
    end

endmodule

@@ rtl/mcerl_back.sv @@
module mcerl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_range_limit,
    input  logic                i_work_valid,
    input  mcerl_pkg::t_work    i_work,
    output logic                o_work_pop,
    output logic                empty,
    input  logic                pop,
    output mcerl_pkg::t_result  o_result
);

    // run state
    logic                          r_run_open;
    logic                          r_run_logged;
    logic [31:0]                   r_total;
    logic [mcerl_pkg::CNT_W-1:0]   r_stored;

    // run table
    logic [mcerl_pkg::ADDR_WIDTH-1:0] r_first [mcerl_pkg::RANGE_DEPTH];
    logic [mcerl_pkg::ADDR_WIDTH:0]   r_end   [mcerl_pkg::RANGE_DEPTH];

    // result queue
    mcerl_pkg::t_result               r_q [mcerl_pkg::Q_DEPTH];
    logic [mcerl_pkg::Q_PTR_W-1:0]    r_wptr;
    logic [mcerl_pkg::Q_PTR_W-1:0]    r_rptr;
    logic [mcerl_pkg::Q_CNT_W-1:0]    r_count;

    logic                          n_run_open;
    logic                          n_run_logged;
    logic [31:0]                   n_total;
    logic [mcerl_pkg::CNT_W-1:0]   n_stored;
    logic                          w_wr_first;
    logic                          w_wr_end;
    logic [mcerl_pkg::IDX_W-1:0]   w_wr_idx;
    logic [mcerl_pkg::CNT_W-1:0]   w_limit;
    logic                          w_room;
    logic                          w_go;
    logic                          w_res_pop;
    logic [mcerl_pkg::IDX_W-1:0]   w_rd_idx;
    mcerl_pkg::t_result            w_res;

    assign w_limit = (32'(i_range_limit) > 32'(mcerl_pkg::RANGE_DEPTH))
                   ? mcerl_pkg::CNT_W'(mcerl_pkg::RANGE_DEPTH)
                   : mcerl_pkg::CNT_W'(i_range_limit);
    assign w_room  = (r_stored < w_limit)
                  && (r_stored < mcerl_pkg::CNT_W'(mcerl_pkg::RANGE_DEPTH));

    assign empty     = (r_count == '0);
    assign w_res_pop = pop && !empty;
    assign w_go      = i_work_valid
                    && ((r_count != mcerl_pkg::Q_CNT_W'(mcerl_pkg::Q_DEPTH)) || w_res_pop);
    assign o_work_pop = w_go;
    assign o_result  = r_q[r_rptr];
    assign w_rd_idx  = mcerl_pkg::IDX_W'(i_work.idx);

    always_comb begin
        n_run_open   = r_run_open;
        n_run_logged = r_run_logged;
        n_total      = r_total;
        n_stored     = r_stored;
        w_wr_first   = 1'b0;
        w_wr_end     = 1'b0;
        w_wr_idx     = r_stored[mcerl_pkg::IDX_W-1:0];
        case (i_work.cmd)
            mcerl_pkg::CMD_CHECK: begin
                if (!i_work.bad) begin
                    n_run_open   = 1'b0;
                    n_run_logged = 1'b0;
                end else if (!r_run_open) begin
                    if (r_total != '1) begin
                        n_total = r_total + 32'd1;
                    end
                    n_run_open   = 1'b1;
                    n_run_logged = w_room;
                    if (w_room) begin
                        w_wr_first = 1'b1;
                        w_wr_end   = 1'b1;
                        n_stored   = r_stored + 1'b1;
                    end
                end else if (r_run_logged) begin
                    // stretch the run that owns the last entry
                    w_wr_end = 1'b1;
                    w_wr_idx = mcerl_pkg::IDX_W'(r_stored - 1'b1);
                end
            end
            mcerl_pkg::CMD_SCAN: begin
                n_run_open   = 1'b0;
                n_run_logged = 1'b0;
            end
            mcerl_pkg::CMD_CLEAR: begin
                n_run_open   = 1'b0;
                n_run_logged = 1'b0;
                n_total      = '0;
                n_stored     = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_res.word_bad    = i_work.bad;
        w_res.total_runs  = n_total;
        w_res.stored_runs = 5'(n_stored);
        w_res.entry_valid = (i_work.cmd == mcerl_pkg::CMD_READ)
                         && (mcerl_pkg::CNT_W'(i_work.idx) < r_stored);
        w_res.entry_first = '0;
        w_res.entry_end   = '0;
        if (w_res.entry_valid) begin
            w_res.entry_first = 32'(r_first[w_rd_idx]);
            w_res.entry_end   = 33'(r_end[w_rd_idx]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open   <= 1'b0;
            r_run_logged <= 1'b0;
            r_total      <= '0;
            r_stored     <= '0;
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_count      <= '0;
        end else begin
            if (w_go) begin
                r_run_open   <= n_run_open;
                r_run_logged <= n_run_logged;
                r_total      <= n_total;
                r_stored     <= n_stored;
                r_wptr       <= r_wptr + 1'b1;
            end
            if (w_res_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_go && !w_res_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_res_pop && !w_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_q[r_wptr] <= w_res;
            if (w_wr_first) begin
                r_first[w_wr_idx] <= i_work.addr;
            end
            if (w_wr_end) begin
                r_end[w_wr_idx] <= i_work.end_addr;
            end
        end
    end

endmodule

@@ rtl/memory_check_error_range_logger.sv @@
// Channel   Handshake          Payload
// request   push / full        i_command, i_word_address, i_word_data, i_entry_index
// result    empty / pop        o_word_bad, o_total_runs, o_stored_runs, o_entry_valid,
//                              o_entry_first, o_entry_end
// config    i_cfg_we           i_cfg_idx (0 pattern, 1 range_limit), i_cfg_wdata
//
// One request per cycle sustained while results are popped. The front classifies a
// request (mask test, end address) into a 2-entry queue; the back applies it to the
// run state and the 16-entry run table and writes a 2-entry result queue. A result
// shows on the ports after its request has passed the front and result queues.
// Synchronous active-low reset empties both queues and clears run state and counts,
// not table contents. Either side stalls alone until its queue fills.
module memory_check_error_range_logger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_word_address,
    input  logic [63:0] i_word_data,
    input  logic [3:0]  i_entry_index,
    output logic        empty,
    input  logic        pop,
    output logic        o_word_bad,
    output logic [31:0] o_total_runs,
    output logic [4:0]  o_stored_runs,
    output logic        o_entry_valid,
    output logic [31:0] o_entry_first,
    output logic [32:0] o_entry_end,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);

    // configuration registers
    logic [63:0]        r_pattern;
    logic [4:0]         r_range_limit;

    logic               w_work_valid;
    logic               w_work_pop;
    mcerl_pkg::t_work   w_work;
    mcerl_pkg::t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_range_limit <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcerl_pkg::CFG_PATTERN:     r_pattern     <= i_cfg_wdata;
                mcerl_pkg::CFG_RANGE_LIMIT: r_range_limit <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify and queue requests
    mcerl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_word_address (i_word_address),
        .i_word_data    (i_word_data),
        .i_entry_index  (i_entry_index),
        .i_pattern      (r_pattern),
        .o_work_valid   (w_work_valid),
        .o_work         (w_work),
        .i_work_pop     (w_work_pop)
    );

    // back: run tracking, table update and readback, result queue
    mcerl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_range_limit (r_range_limit),
        .i_work_valid  (w_work_valid),
        .i_work        (w_work),
        .o_work_pop    (w_work_pop),
        .empty         (empty),
        .pop           (pop),
        .o_result      (w_result)
    );

    assign o_word_bad    = w_result.word_bad;
    assign o_total_runs  = w_result.total_runs;
    assign o_stored_runs = w_result.stored_runs;
    assign o_entry_valid = w_result.entry_valid;
    assign o_entry_first = w_result.entry_first;
    assign o_entry_end   = w_result.entry_end;

endmodule
